[rtl/core/tfp_pkg.sv]
// tfp_pkg: shared types, constants and helpers of the triangle frame projection
// used by every file of the block; depends on nothing else

package tfp_pkg;

  // fixed widths of the query and result words and of the config port
  localparam int IO_BITS  = 20;
  localparam int REG_W    = 60;
  localparam int CFG_IDX_W = 3;
  localparam int WIDE_W   = IO_BITS + 4;

  localparam logic signed [IO_BITS-1:0] OUT_MAX = {1'b0, {(IO_BITS-1){1'b1}}};
  localparam logic signed [IO_BITS-1:0] OUT_MIN = {1'b1, {(IO_BITS-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_AB      = 3'd0,
    REG_EDGE_AC      = 3'd1,
    REG_PLANE_NORMAL = 3'd2,
    REG_UPPER_NORMAL = 3'd3,
    REG_LOWER_NORMAL = 3'd4
  } reg_idx_t;

  // classified query passed from front to back
  typedef struct packed {
    logic signed [IO_BITS-1:0] qx;
    logic signed [IO_BITS-1:0] qy;
    logic signed [IO_BITS-1:0] qz;
    logic                      below;
  } item_t;

  // signed quotient from magnitude, sign and overflow, clamped to the word range
  function automatic logic signed [IO_BITS-1:0] sat_quot(input logic [IO_BITS-1:0] mag,
                                                         input logic neg,
                                                         input logic ovf);
    logic signed [IO_BITS+1:0] v;
    logic signed [IO_BITS-1:0] res;
    v = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    if (ovf) begin
      res = neg ? OUT_MIN : OUT_MAX;
    end else if (v > (IO_BITS+2)'(OUT_MAX)) begin
      res = OUT_MAX;
    end else if (v < (IO_BITS+2)'(OUT_MIN)) begin
      res = OUT_MIN;
    end else begin
      res = $signed(v[IO_BITS-1:0]);
    end
    return res;
  endfunction

  // clamp a wide signed value to the word range
  function automatic logic signed [IO_BITS-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
    logic signed [IO_BITS-1:0] res;
    if (v > WIDE_W'(OUT_MAX)) begin
      res = OUT_MAX;
    end else if (v < WIDE_W'(OUT_MIN)) begin
      res = OUT_MIN;
    end else begin
      res = $signed(v[IO_BITS-1:0]);
    end
    return res;
  endfunction

endpackage

[rtl/core/tfp_if.sv]
// tfp_in_if / tfp_out_if: valid-ready channels of the query and result words
// depends on tfp_pkg for the word widths

interface tfp_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [tfp_pkg::IO_BITS-1:0] query_x;
  logic signed [tfp_pkg::IO_BITS-1:0] query_y;
  logic signed [tfp_pkg::IO_BITS-1:0] query_z;

  modport source (output valid, query_x, query_y, query_z, input ready);
  modport sink   (input valid, query_x, query_y, query_z, output ready);
endinterface

interface tfp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tfp_pkg::IO_BITS-1:0] weight_a;
  logic signed [tfp_pkg::IO_BITS-1:0] weight_b;
  logic signed [tfp_pkg::IO_BITS-1:0] weight_c;
  logic signed [tfp_pkg::IO_BITS-1:0] height;
  logic                              below_plane;
  logic                              singular;

  modport source (output valid, weight_a, weight_b, weight_c, height, below_plane, singular,
                  input ready);
  modport sink   (input valid, weight_a, weight_b, weight_c, height, below_plane, singular,
                  output ready);
endinterface

[rtl/core/tfp_front.sv]
// tfp_front: accepts query words and classifies them against the plane normal
// depends on tfp_pkg and tfp_in_if

module tfp_front #(
  parameter int COMP_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tfp_in_if.sink                     in_ch,
  input  logic [tfp_pkg::REG_W-1:0]  plane_normal,
  output logic                       push_valid,
  input  logic                       push_ready,
  output tfp_pkg::item_t             push_item
);

  localparam int IO  = tfp_pkg::IO_BITS;
  localparam int EW  = 3 * COMP_BITS + tfp_pkg::REG_W;
  localparam int PRW = IO + COMP_BITS;
  localparam int SW  = PRW + 2;

  logic [EW-1:0]                pn_ext;
  logic signed [COMP_BITS-1:0]  pn [3];
  logic signed [PRW-1:0]        px, py, pz;
  logic signed [SW-1:0]         dot;
  logic                         fv_r;
  tfp_pkg::item_t               fitem_r;

  // unpack plane normal
  assign pn_ext = EW'(plane_normal);
  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign pn[i] = $signed(pn_ext[i*COMP_BITS +: COMP_BITS]);
  end

  // side test
  assign px  = PRW'(in_ch.query_x) * PRW'(pn[0]);
  assign py  = PRW'(in_ch.query_y) * PRW'(pn[1]);
  assign pz  = PRW'(in_ch.query_z) * PRW'(pn[2]);
  assign dot = SW'(px) + SW'(py) + SW'(pz);

  assign in_ch.ready = !fv_r || push_ready;

  // front register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ch.ready) begin
      fv_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      fitem_r.qx    <= in_ch.query_x;
      fitem_r.qy    <= in_ch.query_y;
      fitem_r.qz    <= in_ch.query_z;
      fitem_r.below <= dot[SW-1];
    end
  end

  assign push_valid = fv_r;
  assign push_item  = fitem_r;

endmodule

[rtl/core/tfp_queue.sv]
// tfp_queue: two-entry queue between front and back
// depends on tfp_pkg for the word type

module tfp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  tfp_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tfp_pkg::item_t pop_item
);

  tfp_pkg::item_t mem [2];
  logic [1:0]     count_r, count_nxt;
  logic           wr_ptr_r, rd_ptr_r;
  logic           push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_item;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 2'd1)
    else $error("queue push lost");

endmodule

[rtl/core/tfp_back.sv]
// tfp_back: frame cross products, Cramer numerators and pipelined dividers
// depends on tfp_pkg and tfp_out_if

module tfp_back #(
  parameter int FRAC_BITS = 12,
  parameter int COMP_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  tfp_pkg::item_t             pop_item,
  input  logic [tfp_pkg::REG_W-1:0]  edge_ab,
  input  logic [tfp_pkg::REG_W-1:0]  edge_ac,
  input  logic [tfp_pkg::REG_W-1:0]  upper_normal,
  input  logic [tfp_pkg::REG_W-1:0]  lower_normal,
  tfp_out_if.source                  out_ch
);

  localparam int IO  = tfp_pkg::IO_BITS;
  localparam int CW  = COMP_BITS;
  localparam int EW  = 3 * CW + tfp_pkg::REG_W;
  localparam int PRW = 2 * CW;
  localparam int XW  = PRW + 1;
  localparam int QW  = IO + XW;
  localparam int DW  = CW + XW;
  localparam int PW  = ((IO > CW) ? IO : CW) + XW + 2;
  localparam int RW  = PW + IO + 1;
  localparam int WW  = tfp_pkg::WIDE_W;
  localparam logic signed [WW-1:0] ONE = WW'(1) << FRAC_BITS;

  // a*b - c*d at full width
  function automatic logic signed [XW-1:0] xterm(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b,
                                                 input logic signed [CW-1:0] c,
                                                 input logic signed [CW-1:0] d);
    logic signed [PRW-1:0] p, r;
    p = PRW'(a) * PRW'(b);
    r = PRW'(c) * PRW'(d);
    return XW'(p) - XW'(r);
  endfunction

  function automatic logic signed [PW-1:0] dot_q(input logic signed [IO-1:0] q0,
                                                 input logic signed [IO-1:0] q1,
                                                 input logic signed [IO-1:0] q2,
                                                 input logic signed [XW-1:0] c0,
                                                 input logic signed [XW-1:0] c1,
                                                 input logic signed [XW-1:0] c2);
    logic signed [QW-1:0] p0, p1, p2;
    p0 = QW'(q0) * QW'(c0);
    p1 = QW'(q1) * QW'(c1);
    p2 = QW'(q2) * QW'(c2);
    return PW'(p0) + PW'(p1) + PW'(p2);
  endfunction

  function automatic logic signed [PW-1:0] dot_e(input logic signed [CW-1:0] e0,
                                                 input logic signed [CW-1:0] e1,
                                                 input logic signed [CW-1:0] e2,
                                                 input logic signed [XW-1:0] c0,
                                                 input logic signed [XW-1:0] c1,
                                                 input logic signed [XW-1:0] c2);
    logic signed [DW-1:0] p0, p1, p2;
    p0 = DW'(e0) * DW'(c0);
    p1 = DW'(e1) * DW'(c1);
    p2 = DW'(e2) * DW'(c2);
    return PW'(p0) + PW'(p1) + PW'(p2);
  endfunction

  logic en;
  logic out_v_r;

  // whole pipe advances unless the output word is held
  assign en        = !out_v_r || out_ch.ready;
  assign pop_ready = en;

  // unpack frame vectors
  logic [EW-1:0]               ab_ext, ac_ext, n_ext;
  logic signed [CW-1:0]        e1 [3];
  logic signed [CW-1:0]        e2 [3];
  logic signed [CW-1:0]        nn [3];

  assign ab_ext = EW'(edge_ab);
  assign ac_ext = EW'(edge_ac);
  assign n_ext  = pop_item.below ? EW'(lower_normal) : EW'(upper_normal);
  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign e1[i] = $signed(ab_ext[i*CW +: CW]);
    assign e2[i] = $signed(ac_ext[i*CW +: CW]);
    assign nn[i] = $signed(n_ext[i*CW +: CW]);
  end

  // stage 1: cross products of the chosen frame
  logic                   v1_r;
  tfp_pkg::item_t         it1_r;
  logic signed [CW-1:0]   e1_1_r  [3];
  logic signed [XW-1:0]   c12_1_r [3];
  logic signed [XW-1:0]   c20_1_r [3];
  logic signed [XW-1:0]   c01_1_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r      <= pop_item;
      e1_1_r     <= e1;
      c12_1_r[0] <= xterm(e2[1], nn[2], e2[2], nn[1]);
      c12_1_r[1] <= xterm(e2[2], nn[0], e2[0], nn[2]);
      c12_1_r[2] <= xterm(e2[0], nn[1], e2[1], nn[0]);
      c20_1_r[0] <= xterm(nn[1], e1[2], nn[2], e1[1]);
      c20_1_r[1] <= xterm(nn[2], e1[0], nn[0], e1[2]);
      c20_1_r[2] <= xterm(nn[0], e1[1], nn[1], e1[0]);
      c01_1_r[0] <= xterm(e1[1], e2[2], e1[2], e2[1]);
      c01_1_r[1] <= xterm(e1[2], e2[0], e1[0], e2[2]);
      c01_1_r[2] <= xterm(e1[0], e2[1], e1[1], e2[0]);
    end
  end

  // stage 2: numerators and determinant
  logic                 v2_r;
  logic                 below_2_r;
  logic signed [PW-1:0] num_2_r [3];
  logic signed [PW-1:0] det_2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      below_2_r  <= it1_r.below;
      num_2_r[0] <= dot_q(it1_r.qx, it1_r.qy, it1_r.qz, c12_1_r[0], c12_1_r[1], c12_1_r[2]);
      num_2_r[1] <= dot_q(it1_r.qx, it1_r.qy, it1_r.qz, c20_1_r[0], c20_1_r[1], c20_1_r[2]);
      num_2_r[2] <= dot_q(it1_r.qx, it1_r.qy, it1_r.qz, c01_1_r[0], c01_1_r[1], c01_1_r[2]);
      det_2_r    <= dot_e(e1_1_r[0], e1_1_r[1], e1_1_r[2], c12_1_r[0], c12_1_r[1], c12_1_r[2]);
    end
  end

  // stage 3 and divider pipe: index 0 holds magnitudes and overflow flags
  logic              dv_r    [IO+1];
  logic              below_r [IO+1];
  logic              sing_r  [IO+1];
  logic [RW-1:0]     ud_r    [IO+1];
  logic [RW-1:0]     rem_r   [IO+1][3];
  logic [IO-1:0]     quo_r   [IO+1][3];
  logic              neg_r   [IO+1][3];
  logic              ovf_r   [IO+1][3];

  logic [PW-1:0]     ud_abs;
  logic [RW-1:0]     ud_top;

  assign ud_abs = det_2_r[PW-1] ? PW'(-det_2_r) : PW'(det_2_r);
  assign ud_top = RW'(ud_abs) << IO;

  always_ff @(posedge clk) begin
    if (en) begin
      below_r[0] <= below_2_r;
      sing_r[0]  <= (det_2_r == '0);
      ud_r[0]    <= RW'(ud_abs);
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [PW-1:0] un;
    logic [RW-1:0] dividend;
    assign un       = num_2_r[l][PW-1] ? PW'(-num_2_r[l]) : PW'(num_2_r[l]);
    assign dividend = RW'(un) << FRAC_BITS;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[0][l] <= dividend;
        quo_r[0][l] <= '0;
        neg_r[0][l] <= num_2_r[l][PW-1] ^ det_2_r[PW-1];
        ovf_r[0][l] <= (dividend >= ud_top);
      end
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < IO; k++) begin : g_div
    localparam int SH = IO - 1 - k;
    always_ff @(posedge clk) begin
      if (en) begin
        below_r[k+1] <= below_r[k];
        sing_r[k+1]  <= sing_r[k];
        ud_r[k+1]    <= ud_r[k];
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_dl
      logic [RW-1:0] dsh;
      logic          ge;
      assign dsh = ud_r[k] << SH;
      assign ge  = (rem_r[k][l] >= dsh);
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1][l] <= ge ? (rem_r[k][l] - dsh) : rem_r[k][l];
          quo_r[k+1][l] <= {quo_r[k][l][IO-2:0], ge};
          neg_r[k+1][l] <= neg_r[k][l];
          ovf_r[k+1][l] <= ovf_r[k][l];
        end
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int k = 0; k <= IO; k++) dv_r[k] <= 1'b0;
    end else if (en) begin
      v1_r    <= pop_valid;
      v2_r    <= v1_r;
      dv_r[0] <= v2_r;
      for (int k = 0; k < IO; k++) dv_r[k+1] <= dv_r[k];
    end
  end

  // final sign, saturation and third weight
  logic signed [IO-1:0] wa, wb, wh, wc;
  logic signed [WW-1:0] wc_wide;

  assign wa      = tfp_pkg::sat_quot(quo_r[IO][0], neg_r[IO][0], ovf_r[IO][0]);
  assign wb      = tfp_pkg::sat_quot(quo_r[IO][1], neg_r[IO][1], ovf_r[IO][1]);
  assign wh      = tfp_pkg::sat_quot(quo_r[IO][2], neg_r[IO][2], ovf_r[IO][2]);
  assign wc_wide = ONE - WW'(wa) - WW'(wb);
  assign wc      = tfp_pkg::sat_wide(wc_wide);

  // output register
  logic signed [IO-1:0] wa_r, wb_r, wc_r, wh_r;
  logic                 below_o_r, sing_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_r[IO];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      below_o_r <= below_r[IO];
      sing_o_r  <= sing_r[IO];
      wa_r      <= sing_r[IO] ? '0 : wa;
      wb_r      <= sing_r[IO] ? '0 : wb;
      wc_r      <= sing_r[IO] ? '0 : wc;
      wh_r      <= sing_r[IO] ? '0 : wh;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.weight_a    = wa_r;
  assign out_ch.weight_b    = wb_r;
  assign out_ch.weight_c    = wc_r;
  assign out_ch.height      = wh_r;
  assign out_ch.below_plane = below_o_r;
  assign out_ch.singular    = sing_o_r;

  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> v1_r) else $error("popped word lost");
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && sing_o_r) |-> (wa_r == '0 && wb_r == '0 && wc_r == '0 && wh_r == '0))
    else $error("singular word carries data");
  a_no_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[0] && !ovf_r[0][0]) |-> (rem_r[0][0] < (ud_r[0] << IO)))
    else $error("quotient would not fit");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[IO] && !en) |=> dv_r[IO]) else $error("pipe dropped a word under stall");

endmodule

[rtl/core/triangle_frame_projection.sv]
// triangle_frame_projection: top level with configuration registers
// depends on tfp_pkg, tfp_if, tfp_front, tfp_queue and tfp_back
//
// Usage: query words (x, y, z, signed Q8.12) arrive on in_ch with valid/ready;
// each produces exactly one result word on out_ch: weights a, b, c, height
// along the chosen normal, the side flag and the singular flag.
// Configuration is written through cfg_we/cfg_idx/cfg_data while the block is
// idle; index 0 edge_ab, 1 edge_ac, 2 plane_normal, 3 upper_normal,
// 4 lower_normal; other indexes are ignored.
// Throughput: one word per cycle, limited by nothing but the output handshake.
// Pipeline: front register, two-entry queue, cross product, numerator,
// magnitude stage, then a 20-stage restoring divider producing one quotient
// bit per stage, and the output register.
// Reset (rst_n low, synchronous) clears the configuration registers to zero
// and empties the pipe. When out_ch.ready is low while a result word is waiting,
// the back pipe holds; the queue and the front register still take up to
// three more words before in_ch.ready drops.

module triangle_frame_projection #(
  parameter int FRAC_BITS = 12,
  parameter int COMP_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tfp_in_if.sink                        in_ch,
  tfp_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [tfp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tfp_pkg::REG_W-1:0]     cfg_data
);

  logic [tfp_pkg::REG_W-1:0] edge_ab_r, edge_ac_r, plane_normal_r;
  logic [tfp_pkg::REG_W-1:0] upper_normal_r, lower_normal_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_ab_r      <= '0;
      edge_ac_r      <= '0;
      plane_normal_r <= '0;
      upper_normal_r <= '0;
      lower_normal_r <= '0;
    end else if (cfg_we) begin
      unique case (tfp_pkg::reg_idx_t'(cfg_idx))
        tfp_pkg::REG_EDGE_AB:      edge_ab_r      <= cfg_data;
        tfp_pkg::REG_EDGE_AC:      edge_ac_r      <= cfg_data;
        tfp_pkg::REG_PLANE_NORMAL: plane_normal_r <= cfg_data;
        tfp_pkg::REG_UPPER_NORMAL: upper_normal_r <= cfg_data;
        tfp_pkg::REG_LOWER_NORMAL: lower_normal_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic           push_valid, push_ready, pop_valid, pop_ready;
  tfp_pkg::item_t push_item, pop_item;

  tfp_front #(.COMP_BITS(COMP_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .plane_normal (plane_normal_r),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  tfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  tfp_back #(.FRAC_BITS(FRAC_BITS), .COMP_BITS(COMP_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .edge_ab      (edge_ab_r),
    .edge_ac      (edge_ac_r),
    .upper_normal (upper_normal_r),
    .lower_normal (lower_normal_r),
    .out_ch       (out_ch)
  );

endmodule

[dv/triangle_frame_projection_tb.sv]
// triangle_frame_projection_tb: drives query words through the block under a
// series of triangle frames and checks every result word against its own predictor
// depends on tfp_pkg, tfp_if and the triangle_frame_projection rtl

module triangle_frame_projection_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 12;
  localparam int COMP = 20;
  localparam int ONE_Q = 1 << FRAC;
  localparam int PHASE_ITEMS = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [tfp_pkg::CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd5;
  localparam logic [tfp_pkg::CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

  typedef logic signed [tfp_pkg::IO_BITS-1:0] word_t;

  typedef struct packed {
    word_t qx;
    word_t qy;
    word_t qz;
  } query_t;

  typedef struct packed {
    word_t wa;
    word_t wb;
    word_t wc;
    word_t h;
    logic  below;
    logic  sing;
  } proj_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [tfp_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [tfp_pkg::REG_W-1:0] cfg_data = '0;

  tfp_in_if in_ch ();
  tfp_out_if out_ch ();

  triangle_frame_projection #(
    .FRAC_BITS(FRAC),
    .COMP_BITS(COMP)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  // mirror of the frame registers
  logic [tfp_pkg::REG_W-1:0] frame_regs [5];

  query_t pending_q[$];
  proj_t projection_q[$];
  int errors = 0;
  int cycles = 0;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // signed component of a packed vector
  function automatic longint comp(logic [tfp_pkg::REG_W-1:0] r, int i);
    logic signed [COMP-1:0] c;
    c = r[i*COMP +: COMP];
    return longint'(c);
  endfunction

  function automatic longint sat_word(longint v);
    if (v > longint'(tfp_pkg::OUT_MAX)) return longint'(tfp_pkg::OUT_MAX);
    if (v < longint'(tfp_pkg::OUT_MIN)) return longint'(tfp_pkg::OUT_MIN);
    return v;
  endfunction

  // truncated fixed-point quotient, integer part capped before the fraction bits
  function automatic word_t fixed_quot(longint num, longint den);
    logic neg;
    logic [63:0] un, ud, ip, rem, mag;
    longint v;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? 64'(-num) : 64'(num);
    ud = (den < 0) ? 64'(-den) : 64'(den);
    ip = un / ud;
    rem = un % ud;
    if (ip > (64'd1 << tfp_pkg::IO_BITS)) ip = 64'd1 << tfp_pkg::IO_BITS;
    mag = ip;
    for (int i = 0; i < FRAC; i++) begin
      rem = rem << 1;
      mag = mag << 1;
      if (rem >= ud) begin
        rem = rem - ud;
        mag[0] = 1'b1;
      end
    end
    v = neg ? -longint'(mag) : longint'(mag);
    return word_t'(sat_word(v));
  endfunction

  // solve q = a*e1 + b*e2 + h*n for the frame picked by the plane side
  function automatic proj_t project_query(query_t q);
    longint qv[3], e1[3], e2[3], pn[3], n[3], c12[3], c20[3], c01[3];
    longint det;
    logic [tfp_pkg::REG_W-1:0] nreg;
    proj_t r;
    qv[0] = longint'(q.qx);
    qv[1] = longint'(q.qy);
    qv[2] = longint'(q.qz);
    for (int i = 0; i < 3; i++) begin
      e1[i] = comp(frame_regs[tfp_pkg::REG_EDGE_AB], i);
      e2[i] = comp(frame_regs[tfp_pkg::REG_EDGE_AC], i);
      pn[i] = comp(frame_regs[tfp_pkg::REG_PLANE_NORMAL], i);
    end
    r = '0;
    r.below = (qv[0]*pn[0] + qv[1]*pn[1] + qv[2]*pn[2]) < 0;
    nreg = r.below ? frame_regs[tfp_pkg::REG_LOWER_NORMAL]
                   : frame_regs[tfp_pkg::REG_UPPER_NORMAL];
    for (int i = 0; i < 3; i++) n[i] = comp(nreg, i);
    c12[0] = e2[1]*n[2] - e2[2]*n[1];
    c12[1] = e2[2]*n[0] - e2[0]*n[2];
    c12[2] = e2[0]*n[1] - e2[1]*n[0];
    c20[0] = n[1]*e1[2] - n[2]*e1[1];
    c20[1] = n[2]*e1[0] - n[0]*e1[2];
    c20[2] = n[0]*e1[1] - n[1]*e1[0];
    c01[0] = e1[1]*e2[2] - e1[2]*e2[1];
    c01[1] = e1[2]*e2[0] - e1[0]*e2[2];
    c01[2] = e1[0]*e2[1] - e1[1]*e2[0];
    det = e1[0]*c12[0] + e1[1]*c12[1] + e1[2]*c12[2];
    r.sing = (det == 0);
    if (!r.sing) begin
      r.wa = fixed_quot(qv[0]*c12[0] + qv[1]*c12[1] + qv[2]*c12[2], det);
      r.wb = fixed_quot(qv[0]*c20[0] + qv[1]*c20[1] + qv[2]*c20[2], det);
      r.h  = fixed_quot(qv[0]*c01[0] + qv[1]*c01[1] + qv[2]*c01[2], det);
      r.wc = word_t'(sat_word(longint'(ONE_Q) - longint'(r.wa) - longint'(r.wb)));
    end
    return r;
  endfunction

  function automatic logic [tfp_pkg::REG_W-1:0] pack_vec(longint x, longint y, longint z);
    logic [COMP-1:0] px, py, pz;
    px = x[COMP-1:0];
    py = y[COMP-1:0];
    pz = z[COMP-1:0];
    return {pz, py, px};
  endfunction

  // random frame vector: full range, small near-unit, or extreme components
  function automatic logic [tfp_pkg::REG_W-1:0] rand_vec(int mode);
    longint c[3];
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0: c[i] = longint'($signed(20'($urandom)));
        1: c[i] = longint'($urandom_range(0, 16384)) - 8192;
        default: begin
          case ($urandom_range(0, 2))
            0: c[i] = longint'(tfp_pkg::OUT_MAX);
            1: c[i] = longint'(tfp_pkg::OUT_MIN);
            default: c[i] = 0;
          endcase
        end
      endcase
    end
    return pack_vec(c[0], c[1], c[2]);
  endfunction

  function automatic word_t rand_comp();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return tfp_pkg::OUT_MAX;
          1: return tfp_pkg::OUT_MIN;
          2: return '0;
          3: return word_t'(1);
          default: return word_t'(-1);
        endcase
      end
      default: return word_t'(int'($urandom_range(0, 16384)) - 8192);
    endcase
  endfunction

  function automatic query_t make_query(word_t x, word_t y, word_t z);
    query_t q;
    q.qx = x;
    q.qy = y;
    q.qz = z;
    return q;
  endfunction

  // register write, mirrored as it is driven if the index names a frame register
  task automatic write_reg(logic [tfp_pkg::CFG_IDX_W-1:0] idx,
                           logic [tfp_pkg::REG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    if (idx <= tfp_pkg::REG_LOWER_NORMAL) frame_regs[idx] = val;
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_frame(logic [tfp_pkg::REG_W-1:0] e1, logic [tfp_pkg::REG_W-1:0] e2,
                             logic [tfp_pkg::REG_W-1:0] pn, logic [tfp_pkg::REG_W-1:0] up,
                             logic [tfp_pkg::REG_W-1:0] lo);
    write_reg(tfp_pkg::REG_EDGE_AB, e1);
    write_reg(tfp_pkg::REG_EDGE_AC, e2);
    write_reg(tfp_pkg::REG_PLANE_NORMAL, pn);
    write_reg(tfp_pkg::REG_UPPER_NORMAL, up);
    write_reg(tfp_pkg::REG_LOWER_NORMAL, lo);
    end_writes();
  endtask

  // wait until every word is through, then let the pipe settle
  task automatic wait_idle();
    wait (pending_q.size() == 0 && projection_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_random(int count);
    for (int i = 0; i < count; i++)
      pending_q.push_back(make_query(rand_comp(), rand_comp(), rand_comp()));
  endtask

  task automatic push_corners();
    word_t vals[5];
    vals = '{'0, tfp_pkg::OUT_MAX, tfp_pkg::OUT_MIN, word_t'(ONE_Q), word_t'(-ONE_Q)};
    pending_q.push_back(make_query('0, '0, '0));
    for (int i = 1; i < 5; i++) begin
      pending_q.push_back(make_query(vals[i], '0, '0));
      pending_q.push_back(make_query('0, vals[i], '0));
      pending_q.push_back(make_query('0, '0, vals[i]));
    end
    pending_q.push_back(make_query(tfp_pkg::OUT_MAX, tfp_pkg::OUT_MAX, tfp_pkg::OUT_MAX));
    pending_q.push_back(make_query(tfp_pkg::OUT_MIN, tfp_pkg::OUT_MIN, tfp_pkg::OUT_MIN));
    pending_q.push_back(make_query(tfp_pkg::OUT_MAX, tfp_pkg::OUT_MIN, tfp_pkg::OUT_MAX));
  endtask

  // stimulus and phase sequencing
  initial begin
    logic [tfp_pkg::REG_W-1:0] e1;
    for (int i = 0; i < 5; i++) frame_regs[i] = '0;
    in_ch.valid = 1'b0;
    in_ch.query_x = '0;
    in_ch.query_y = '0;
    in_ch.query_z = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // all-zero frame after reset: singular, upper side
    push_corners();
    wait_idle();

    // unit frame with opposite tangent normals
    write_frame(pack_vec(ONE_Q, 0, 0), pack_vec(0, ONE_Q, 0), pack_vec(0, 0, ONE_Q),
                pack_vec(0, 0, ONE_Q), pack_vec(0, 0, -ONE_Q));
    push_corners();
    push_random(PHASE_ITEMS);
    wait_idle();

    // writes to unused indexes must leave the frame alone
    for (logic [tfp_pkg::CFG_IDX_W-1:0] k = IDX_UNUSED_LO; k <= IDX_UNUSED_HI; k++) begin
      write_reg(k, rand_vec(0));
      if (k == IDX_UNUSED_HI) break;
    end
    end_writes();
    push_random(60);
    wait_idle();

    // random frames of each flavor
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0, 3: write_frame(rand_vec(1), rand_vec(1), rand_vec(1), rand_vec(1), rand_vec(1));
        1: write_frame(rand_vec(0), rand_vec(0), rand_vec(0), rand_vec(0), rand_vec(0));
        2: write_frame(rand_vec(2), rand_vec(2), rand_vec(2), rand_vec(2), rand_vec(2));
        4: begin
          // colinear edges: singular on both sides
          e1 = rand_vec(1);
          write_frame(e1, e1, rand_vec(1), rand_vec(1), rand_vec(1));
        end
        default: begin
          // singular only above the plane
          write_frame(rand_vec(1), rand_vec(1), rand_vec(1), '0, rand_vec(1));
        end
      endcase
      push_random(PHASE_ITEMS + (ph == 0 ? 150 : 0));
      wait_idle();
    end

    if (errors == 0) begin
      $display("** triangle_frame_projection: PASSED **");
    end else begin
      $display("** triangle_frame_projection: FAILED **");
    end
    $finish;
  end

  // query driver: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic fire;
    logic nxt_valid;
    fire = in_ch.valid && in_ch.ready;
    nxt_valid = in_ch.valid && !fire;
    if (fire) begin
      projection_q.push_back(project_query(pending_q[0]));
      void'(pending_q.pop_front());
    end
    if (rst_n && !nxt_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        nxt_valid = 1'b1;
        in_ch.query_x <= pending_q[0].qx;
        in_ch.query_y <= pending_q[0].qy;
        in_ch.query_z <= pending_q[0].qz;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_ch.valid <= nxt_valid;
  end

  // result monitor: checks each result word; the stall pattern changes mode as the run goes on
  int stall_mode = 0;
  always @(posedge clk) begin
    proj_t exp_r;
    logic rdy;
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (out_ch.valid && out_ch.ready) begin
      if (projection_q.size() == 0) begin
        $error("result word with no query pending");
        errors++;
      end else begin
        exp_r = projection_q.pop_front();
        if (out_ch.weight_a !== exp_r.wa) begin
          $error("weight_a expected %0d got %0d", exp_r.wa, out_ch.weight_a);
          errors++;
        end
        if (out_ch.weight_b !== exp_r.wb) begin
          $error("weight_b expected %0d got %0d", exp_r.wb, out_ch.weight_b);
          errors++;
        end
        if (out_ch.weight_c !== exp_r.wc) begin
          $error("weight_c expected %0d got %0d", exp_r.wc, out_ch.weight_c);
          errors++;
        end
        if (out_ch.height !== exp_r.h) begin
          $error("height expected %0d got %0d", exp_r.h, out_ch.height);
          errors++;
        end
        if (out_ch.below_plane !== exp_r.below) begin
          $error("below_plane expected %0b got %0b", exp_r.below, out_ch.below_plane);
          errors++;
        end
        if (out_ch.singular !== exp_r.sing) begin
          $error("singular expected %0b got %0b", exp_r.sing, out_ch.singular);
          errors++;
        end
      end
    end
    case (stall_mode)
      0: rdy = 1'b1;
      1: rdy = 1'($urandom_range(0, 1));
      2: rdy = ($urandom_range(0, 7) == 0);
      default: rdy = ((cycles / 5) % 3) != 0;
    endcase
    out_ch.ready <= rdy;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** triangle_frame_projection: FAILED **");
      $finish;
    end
  end

endmodule

[sim.f]
rtl/core/tfp_pkg.sv
rtl/core/tfp_if.sv
rtl/core/tfp_front.sv
rtl/core/tfp_queue.sv
rtl/core/tfp_back.sv
rtl/core/triangle_frame_projection.sv
dv/triangle_frame_projection_tb.sv
